[hdl/mrtbm_pkg.sv]
// Shared types and constants for the motor run timer and battery monitor.
// No dependencies.
package mrtbm_pkg;

    localparam int TickW     = 32;
    localparam int RunTimeW  = 24;
    localparam int IntervalW = 16;
    localparam int LevelW    = 8;
    localparam int CountW    = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 24;

    localparam logic [RunTimeW-1:0]  RunTimeRst    = 24'd120000;
    localparam logic [IntervalW-1:0] CheckIvlRst   = 16'd1000;
    localparam logic [IntervalW-1:0] BlinkIvlRst   = 16'd500;
    localparam logic [LevelW-1:0]    LowThreshRst  = 8'd215;
    localparam logic [LevelW-1:0]    CutThreshRst  = 8'd205;
    localparam logic [CountW-1:0]    CutLimitRst   = 4'd10;
    localparam logic [CountW-1:0]    CountMax      = 4'd15;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RUN_TIME       = 3'd0,
        CFG_CHECK_INTERVAL = 3'd1,
        CFG_BLINK_INTERVAL = 3'd2,
        CFG_LOW_THRESHOLD  = 3'd3,
        CFG_CUT_THRESHOLD  = 3'd4,
        CFG_CUT_LIMIT      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CHG_OK     = 2'd0,
        CHG_LOW    = 2'd1,
        CHG_CUTOFF = 2'd2
    } charge_state_t;

endpackage

[hdl/motor_run_timer_battery_monitor_unit.sv]
// Motor run timer with battery monitor, top level.
// The result of an accepted item is on the m_ channel from the cycle after its acceptance.
// Throughput: one item per cycle while m_ready keeps the result register free; the tick
// update is one pass of compare and increment logic into the state and result registers.
// Reset (aresetn, synchronous, active low) restores the default settings,
// resets the tick state, leaves the motor idle and empties the result register.
// Depends on mrtbm_pkg.
module motor_run_timer_battery_monitor_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [mrtbm_pkg::CfgIdxW-1:0]    cfg_addr,
    input  logic [mrtbm_pkg::CfgDataW-1:0]   cfg_wr_data,
    // tick items in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_button_level,
    input  logic [mrtbm_pkg::LevelW-1:0]     s_battery_level,
    // result items out
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_motor_on,
    output logic                             m_start_led_pin,
    output logic                             m_battery_led_pin,
    output logic [1:0]                       m_battery_status,
    output logic                             m_halted
);
    import mrtbm_pkg::*;

    // settings
    logic [RunTimeW-1:0]  run_time_reg;
    logic [IntervalW-1:0] check_ivl_reg;
    logic [IntervalW-1:0] blink_ivl_reg;
    logic [LevelW-1:0]    low_thresh_reg;
    logic [LevelW-1:0]    cut_thresh_reg;
    logic [CountW-1:0]    cut_limit_reg;

    // tick state
    logic [TickW-1:0]  tick_count_reg,  tick_count_next;
    logic [TickW-1:0]  run_start_reg,   run_start_next;
    logic [TickW-1:0]  blink_tick_reg,  blink_tick_next;
    logic [TickW-1:0]  check_tick_reg,  check_tick_next;
    logic              running_reg,     running_next;
    logic              last_button_reg, last_button_next;
    charge_state_t     charge_reg,      charge_next;
    logic [CountW-1:0] cut_count_reg,   cut_count_next;
    logic              go_lamp_reg,     go_lamp_next;
    logic              bat_lamp_reg,    bat_lamp_next;
    logic              shut_down_reg,   shut_down_next;

    // result register
    logic              m_valid_reg;
    logic              motor_on_reg;
    logic              start_pin_reg;
    logic              batt_pin_reg;
    charge_state_t     status_reg;
    logic              halted_reg;

    logic              accept;
    logic [TickW-1:0]  run_elapsed;
    logic [TickW-1:0]  blink_elapsed;
    logic [TickW-1:0]  check_elapsed;

    // The result register parts the two sides: take a new item whenever the
    // slot is empty or its item leaves in this same cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // One tick, in the order: count, button edge, run timeout, blink, battery check.
    always_comb begin
        tick_count_next  = tick_count_reg;
        run_start_next   = run_start_reg;
        blink_tick_next  = blink_tick_reg;
        check_tick_next  = check_tick_reg;
        running_next     = running_reg;
        last_button_next = last_button_reg;
        charge_next      = charge_reg;
        cut_count_next   = cut_count_reg;
        go_lamp_next     = go_lamp_reg;
        bat_lamp_next    = bat_lamp_reg;
        shut_down_next   = shut_down_reg;
        run_elapsed      = '0;
        blink_elapsed    = '0;
        check_elapsed    = '0;

        if (!shut_down_reg) begin
            tick_count_next  = tick_count_reg + TickW'(1);

            // a falling edge of the button toggles the motor
            if (!s_button_level && last_button_reg) begin
                if (!running_reg) begin
                    run_start_next = tick_count_next;
                    go_lamp_next   = 1'b1;
                    running_next   = 1'b1;
                end else begin
                    running_next   = 1'b0;
                    go_lamp_next   = 1'b0;
                end
            end
            last_button_next = s_button_level;

            // time out a run that has gone on too long; elapsed times wrap
            run_elapsed = tick_count_next - run_start_next;
            if (running_next && (run_elapsed > TickW'(run_time_reg))) begin
                running_next   = 1'b0;
                go_lamp_next   = 1'b0;
            end

            // blink on the battery state held from the previous tick
            blink_elapsed = tick_count_next - blink_tick_reg;
            if ((charge_reg == CHG_LOW) &&
                (blink_elapsed > TickW'(blink_ivl_reg))) begin
                blink_tick_next = tick_count_next;
                bat_lamp_next   = !bat_lamp_reg;
            end

            // periodic battery check; low never clears, cutoff readings saturate
            check_elapsed = tick_count_next - check_tick_reg;
            if (check_elapsed > TickW'(check_ivl_reg)) begin
                check_tick_next = tick_count_next;
                if (s_battery_level < low_thresh_reg) begin
                    charge_next = CHG_LOW;
                end
                if (s_battery_level < cut_thresh_reg) begin
                    if (cut_count_reg != CountMax) begin
                        cut_count_next = cut_count_reg + CountW'(1);
                    end
                    // latch shutdown: motor off, start LED pin high, battery LED pin low
                    if (cut_count_next > cut_limit_reg) begin
                        charge_next     = CHG_CUTOFF;
                        running_next    = 1'b0;
                        go_lamp_next    = 1'b1;
                        bat_lamp_next   = 1'b0;
                        shut_down_next  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_time_reg    <= RunTimeRst;
            check_ivl_reg   <= CheckIvlRst;
            blink_ivl_reg   <= BlinkIvlRst;
            low_thresh_reg  <= LowThreshRst;
            cut_thresh_reg  <= CutThreshRst;
            cut_limit_reg   <= CutLimitRst;
            tick_count_reg  <= '0;
            run_start_reg   <= '0;
            blink_tick_reg  <= '0;
            check_tick_reg  <= '0;
            running_reg     <= 1'b0;
            last_button_reg <= 1'b1;
            charge_reg      <= CHG_OK;
            cut_count_reg   <= '0;
            go_lamp_reg     <= 1'b0;
            bat_lamp_reg    <= 1'b1;
            shut_down_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // settings writes; an index beyond the list is dropped
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_RUN_TIME:       run_time_reg   <= cfg_wr_data[RunTimeW-1:0];
                    CFG_CHECK_INTERVAL: check_ivl_reg  <= cfg_wr_data[IntervalW-1:0];
                    CFG_BLINK_INTERVAL: blink_ivl_reg  <= cfg_wr_data[IntervalW-1:0];
                    CFG_LOW_THRESHOLD:  low_thresh_reg <= cfg_wr_data[LevelW-1:0];
                    CFG_CUT_THRESHOLD:  cut_thresh_reg <= cfg_wr_data[LevelW-1:0];
                    CFG_CUT_LIMIT:      cut_limit_reg  <= cfg_wr_data[CountW-1:0];
                    default: ;
                endcase
            end

            // advance the tick state on each accepted item
            if (accept) begin
                tick_count_reg  <= tick_count_next;
                run_start_reg   <= run_start_next;
                blink_tick_reg  <= blink_tick_next;
                check_tick_reg  <= check_tick_next;
                running_reg     <= running_next;
                last_button_reg <= last_button_next;
                charge_reg      <= charge_next;
                cut_count_reg   <= cut_count_next;
                go_lamp_reg     <= go_lamp_next;
                bat_lamp_reg    <= bat_lamp_next;
                shut_down_reg   <= shut_down_next;
            end

            // hold the result until taken; refill on accept
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with the post-tick state
    always_ff @(posedge aclk) begin
        if (accept) begin
            motor_on_reg  <= running_next;
            start_pin_reg <= go_lamp_next;
            batt_pin_reg  <= bat_lamp_next;
            status_reg    <= charge_next;
            halted_reg    <= shut_down_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_motor_on        = motor_on_reg;
    assign m_start_led_pin   = start_pin_reg;
    assign m_battery_led_pin = batt_pin_reg;
    assign m_battery_status  = status_reg;
    assign m_halted          = halted_reg;

endmodule
